/* rtl/ff1a_pkg.sv */
// shared types, s-box and aes round functions for the ff1 aes-256 unit
package ff1a_pkg;

  localparam int unsigned HalfW   = 44;
  localparam int unsigned BlockW  = 88;
  localparam int unsigned Rounds  = 10;
  localparam int unsigned AesRnds = 14;
  localparam int unsigned KeyWrds = 60;

  // fixed first cbc-mac block (radix, rounds, u, n, tweak length)
  localparam logic [127:0] PBlock = 128'h01020100_00020A2C_00000058_00000000;

  // configuration register indexes
  localparam logic [1:0] CfgKey0 = 2'd0;
  localparam logic [1:0] CfgKey1 = 2'd1;
  localparam logic [1:0] CfgKey2 = 2'd2;
  localparam logic [1:0] CfgKey3 = 2'd3;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [23:0] plain_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [23:0] cipher_lo;
  } out_t;

  // one word moving between feistel rounds
  typedef struct packed {
    logic              vld;
    logic [HalfW-1:0]  a;
    logic [HalfW-1:0]  b;
  } fword_t;

  typedef logic [AesRnds:0][127:0] rkeys_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // one aes round: subbytes, shiftrows, optional mixcolumns, add round key
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0]   sb [16];
    logic [7:0]   t  [16];
    logic [7:0]   m  [16];
    logic [7:0]   x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) sb[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i+4*c] = sb[i+4*((c+i)%4)];
    for (int c = 0; c < 4; c++) begin
      x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ x ^ xt(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ x ^ xt(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ x ^ xt(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ x ^ xt(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = last ? t[i] : m[i];
    return r ^ rk;
  endfunction

  // reverse the bits within each of the 11 bytes
  function automatic logic [BlockW-1:0] rev_bytes(input logic [BlockW-1:0] x);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 11; i++)
      for (int k = 0; k < 8; k++) r[87-8*i-k] = x[80-8*i+k];
    return r;
  endfunction

  // rcon byte for key word group g (1..7)
  function automatic logic [7:0] rcon(input logic [2:0] g);
    return 8'(8'h01 << (g - 3'd1));
  endfunction

endpackage

/* rtl/ff1a_feistel.sv */
// one ff1 feistel round: 14 aes round stages and one add stage
module ff1a_feistel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        round_i,
  input  ff1a_pkg::rkeys_t  rk_i,
  input  logic [127:0]      ep_i,
  input  ff1a_pkg::fword_t  in_i,
  output ff1a_pkg::fword_t  out_o
);
  import ff1a_pkg::*;

  localparam int unsigned NStg = AesRnds + 1;

  logic               vld_q [NStg];
  logic [HalfW-1:0]   a_q   [NStg];
  logic [HalfW-1:0]   b_q   [NStg];
  logic [127:0]       s_q   [AesRnds];
  logic [127:0]       s_d   [AesRnds];
  logic [127:0]       q_blk;
  logic [HalfW-1:0]   c_d;

  // second cbc-mac block: round number and b
  assign q_blk = {72'h0, 4'h0, round_i, 4'h0, in_i.b};

  // aes round datapath, one round per stage
  always_comb begin
    s_d[0] = aes_round(ep_i ^ q_blk ^ rk_i[0], rk_i[1], 1'b0);
    for (int j = 1; j < AesRnds; j++)
      s_d[j] = aes_round(s_q[j-1], rk_i[j+1], (j == AesRnds - 1));
  end

  // modular add of the prf slice into a
  assign c_d = a_q[AesRnds-1] + s_q[AesRnds-1][75:32];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NStg; j++) vld_q[j] <= 1'b0;
    end else begin
      vld_q[0] <= in_i.vld;
      for (int j = 1; j < NStg; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    a_q[0] <= in_i.a;
    b_q[0] <= in_i.b;
    for (int j = 0; j < AesRnds; j++) s_q[j] <= s_d[j];
    for (int j = 1; j < AesRnds; j++) begin
      a_q[j] <= a_q[j-1];
      b_q[j] <= b_q[j-1];
    end
    a_q[AesRnds] <= b_q[AesRnds-1];
    b_q[AesRnds] <= c_d;
  end

  assign out_o.vld = vld_q[AesRnds];
  assign out_o.a   = a_q[AesRnds];
  assign out_o.b   = b_q[AesRnds];

endmodule

/* rtl/ff1_aes256_radix2_88bit_unit.sv */
// ff1 aes-256 radix-2 88-bit encryption unit, top level
// Usage:
//   Input: drive data_i and pulse start_i; a word is taken at a clock edge
//   where start_i is high and busy_o is low. A new word may be given every
//   cycle while busy_o is low.
//   Output: done_o is high for one cycle with result_o holding the cipher
//   word. Words leave in order. Throughput is one word per cycle while
//   busy_o is low: ten feistel rounds of 15 stages each (14 aes rounds
//   and one 44-bit add) are fully unrolled.
//   Key: cfg_we_i writes cfg_wdata_i into key word cfg_idx_i. Each write and
//   each reset starts the key schedule (one key word a cycle) and the
//   encryption of the fixed first mac block through one aes round unit;
//   busy_o is high until both are done.
//   Reset clears the key to zero and empties the pipeline.
//   The receiver cannot stall; results are shown for one cycle only.
module ff1_aes256_radix2_88bit_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  ff1a_pkg::in_t    data_i,
  output logic             done_o,
  output ff1a_pkg::out_t   result_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [63:0]      cfg_wdata_i
);
  import ff1a_pkg::*;

  typedef enum logic [1:0] {ST_KEXP, ST_EP, ST_READY} state_e;

  state_e          state_q;
  logic [5:0]      cnt_q;
  logic [63:0]     key_q  [4];
  logic [31:0]     win_q  [8];
  logic [31:0]     rkw_q  [KeyWrds];
  logic [127:0]    ep_q;
  logic [31:0]     new_w;
  logic [31:0]     f_w;
  logic [63:0]     kw_sel;
  logic [3:0]      ep_rnd;
  rkeys_t          rk;

  logic            in_vld_q;
  logic [BlockW-1:0] in_ab_q;
  fword_t          chain [Rounds+1];
  logic            done_q;
  out_t            res_q;

  // round keys from the expanded word line
  for (genvar r = 0; r <= AesRnds; r++) begin : g_rk
    assign rk[r] = {rkw_q[4*r], rkw_q[4*r+1], rkw_q[4*r+2], rkw_q[4*r+3]};
  end

  // next key schedule word
  always_comb begin
    kw_sel = key_q[cnt_q[2:1]];
    priority if (cnt_q[2:0] == 3'd0) begin
      f_w = {SBOX[win_q[7][23:16]] ^ rcon(cnt_q[5:3]), SBOX[win_q[7][15:8]],
             SBOX[win_q[7][7:0]], SBOX[win_q[7][31:24]]};
    end else if (cnt_q[2:0] == 3'd4) begin
      f_w = {SBOX[win_q[7][31:24]], SBOX[win_q[7][23:16]],
             SBOX[win_q[7][15:8]], SBOX[win_q[7][7:0]]};
    end else begin
      f_w = win_q[7];
    end
    if (cnt_q < 6'd8) new_w = cnt_q[0] ? kw_sel[31:0] : kw_sel[63:32];
    else              new_w = win_q[0] ^ f_w;
  end

  assign ep_rnd = 4'(cnt_q) + 4'd1;

  // key schedule and fixed block sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_KEXP;
      cnt_q   <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKey0: key_q[0] <= cfg_wdata_i;
        CfgKey1: key_q[1] <= cfg_wdata_i;
        CfgKey2: key_q[2] <= cfg_wdata_i;
        CfgKey3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
      state_q <= ST_KEXP;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_KEXP: begin
          if (cnt_q == 6'(KeyWrds - 1)) begin
            state_q <= ST_EP;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_EP: begin
          if (cnt_q == 6'(AesRnds - 1)) state_q <= ST_READY;
          else                          cnt_q   <= cnt_q + 6'd1;
        end
        ST_READY: ;
        default: state_q <= ST_KEXP;
      endcase
    end
  end

  // key word shift lines and fixed block encryption
  always_ff @(posedge clk_i) begin
    if (state_q == ST_KEXP && !cfg_we_i) begin
      for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
      win_q[7] <= new_w;
      for (int i = 0; i < KeyWrds - 1; i++) rkw_q[i] <= rkw_q[i+1];
      rkw_q[KeyWrds-1] <= new_w;
    end
    if (state_q == ST_EP) begin
      if (cnt_q == 6'd0) ep_q <= aes_round(PBlock ^ rk[0], rk[1], 1'b0);
      else               ep_q <= aes_round(ep_q, rk[ep_rnd], (cnt_q == 6'(AesRnds - 1)));
    end
  end

  assign busy_o = (state_q != ST_READY);

  // input stage: bit-reverse bytes, split into a and b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    in_ab_q <= rev_bytes({data_i.plain_hi, data_i.plain_lo});
  end

  assign chain[0].vld = in_vld_q;
  assign chain[0].a   = in_ab_q[BlockW-1:HalfW];
  assign chain[0].b   = in_ab_q[HalfW-1:0];

  // ten unrolled feistel rounds
  for (genvar k = 0; k < Rounds; k++) begin : g_rnd
    ff1a_feistel u_feistel (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (4'(k)),
      .rk_i    (rk),
      .ep_i    (ep_q),
      .in_i    (chain[k]),
      .out_o   (chain[k+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= chain[Rounds].vld;
  end

  always_ff @(posedge clk_i) begin
    res_q <= out_t'(rev_bytes({chain[Rounds].a, chain[Rounds].b}));
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o) else $error("key write did not restart key schedule");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> in_vld_q) else $error("accepted word not captured");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(state_q == ST_EP)) else $error("ready without fixed block");
`endif

endmodule
